// File: sv/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;

  // Byte order mark, in arrival order
  localparam logic [BYTE_W-1:0] BOM_BYTE0 = 8'hEF;
  localparam logic [BYTE_W-1:0] BOM_BYTE1 = 8'hBB;
  localparam logic [BYTE_W-1:0] BOM_BYTE2 = 8'hBF;

  // Position of a byte in the text, saturating once past the mark
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_PAST   = 2'd3;

  // One input request
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  // One result request
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            has_code_point;
    logic            end_of_text;
    logic            halted;
  } result_t;

endpackage

// File: sv/utf8d_in_stage.sv
// ----------------------------------------------------------------------------
// utf8d_in_stage
// Input register: holds one byte request until the decoder consumes it.
// ----------------------------------------------------------------------------
module utf8d_in_stage
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_vld,
  output logic     req_rdy,
  input  in_item_t req_item,
  input  logic     take,
  output logic     hold_vld,
  output in_item_t hold_item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  // Accept when empty or when the held byte leaves this cycle
  assign req_rdy = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (req_vld && req_rdy) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (req_vld && req_rdy) begin
      item_r <= req_item;
    end
  end

  assign hold_vld  = vld_r;
  assign hold_item = item_r;

endmodule

// File: sv/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and combinational decode of one byte into an optional result.
// ----------------------------------------------------------------------------
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     skip_bom,
  input  logic     step,
  input  in_item_t item,
  output logic     res_vld,
  output result_t  res
);

  logic [1:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            stop_r, stop_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic            match_r, match_nxt;

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] want;
  logic [CP_W-1:0]   cp;
  logic              emit;

  assign b = item.data_byte;

  // Expected mark byte at the current position
  always_comb begin
    case (pos_r)
      POS_FIRST:  want = BOM_BYTE0;
      POS_SECOND: want = BOM_BYTE1;
      default:    want = BOM_BYTE2;
    endcase
  end

  // Decode one byte against the partial sequence
  always_comb begin
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    stop_nxt  = stop_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    cp        = '0;
    emit      = 1'b0;
    if (!stop_r) begin
      if (pend_r == 2'd0) begin
        if (b[7] == 1'b0) begin
          cp   = {{(CP_W-BYTE_W){1'b0}}, b};
          emit = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          acc_nxt  = {{(CP_W-5){1'b0}}, b[4:0]};
          pend_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_nxt  = {{(CP_W-4){1'b0}}, b[3:0]};
          pend_nxt = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          acc_nxt  = {{(CP_W-3){1'b0}}, b[2:0]};
          pend_nxt = 2'd3;
        end else begin
          // Continuation or out-of-range lead byte
          stop_nxt = 1'b1;
        end
      end else begin
        acc_nxt  = {acc_r[CP_W-7:0], b[5:0]};
        pend_nxt = pend_r - 2'd1;
        if (pend_nxt == 2'd0) begin
          cp   = acc_nxt;
          emit = 1'b1;
        end
      end
      // Truncated sequence at end of text
      if (item.last_byte && pend_nxt != 2'd0) begin
        stop_nxt = 1'b1;
      end
      // Track the leading byte order mark
      if (pos_r != POS_PAST) begin
        if (b != want) begin
          match_nxt = 1'b0;
        end
        if (pos_r == POS_THIRD && match_nxt && skip_bom && emit) begin
          emit = 1'b0;
        end
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  // Form the result
  assign res_vld            = item.last_byte || emit;
  assign res.code_point     = emit ? cp : '0;
  assign res.has_code_point = emit;
  assign res.end_of_text    = item.last_byte;
  assign res.halted         = item.last_byte && stop_nxt;

  // Advance state; end of text starts a fresh one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      acc_r   <= '0;
      stop_r  <= 1'b0;
      pos_r   <= POS_FIRST;
      match_r <= 1'b1;
    end else if (step) begin
      if (item.last_byte) begin
        pend_r  <= 2'd0;
        acc_r   <= '0;
        stop_r  <= 1'b0;
        pos_r   <= POS_FIRST;
        match_r <= 1'b1;
      end else begin
        pend_r  <= pend_nxt;
        acc_r   <= acc_nxt;
        stop_r  <= stop_nxt;
        pos_r   <= pos_nxt;
        match_r <= match_nxt;
      end
    end
  end

endmodule

// File: sv/utf8_to_codepoint_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_core
// UTF-8 byte stream in, code points out, with end-of-text and halt flags.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while the output is not stalled: each byte
// passes an input register, a combinational decode against the sequence
// state, and a result register. Bytes that complete no character and are
// not the last of the text produce no result. Output stalls hold the result
// register and, through the input ready, back up the input without losing a
// request.
module utf8_to_codepoint_decoder_core
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // skip_bom
  // Byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // last_byte
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,     // [0] has_code_point, [1] halted
  output logic        out_tlast      // end_of_text
);

  logic     skip_bom_r;
  in_item_t in_item;
  in_item_t hold_item;
  logic     hold_vld;
  logic     out_free;
  logic     step;
  logic     res_vld;
  result_t  res;
  logic     out_vld_r, out_vld_nxt;
  result_t  out_res_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_bom_r <= 1'b1;
    end else if (cfg_wr_en) begin
      skip_bom_r <= cfg_wr_data;
    end
  end

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  // Decode advances when a byte is held and the result slot can take a request
  assign out_free = !out_vld_r || out_tready;
  assign step     = hold_vld && out_free;

  utf8d_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (in_tvalid),
    .req_rdy   (in_tready),
    .req_item  (in_item),
    .take      (step),
    .hold_vld  (hold_vld),
    .hold_item (hold_item)
  );

  utf8d_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .skip_bom (skip_bom_r),
    .step     (step),
    .item     (hold_item),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.code_point};
  assign out_tuser  = {out_res_r.halted, out_res_r.has_code_point};
  assign out_tlast  = out_res_r.end_of_text;

`ifndef ASSERT_OFF
  // A result without a character can only be the end of text
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("result without code point is not end of text");

  // Halt is reported only on the end result
  a_halt_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("halt flag on a result that is not end of text");

  // A result without a code point carries a zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 24'd0)
    else $error("nonzero code point without has_code_point");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
`endif

endmodule
